// File: hdl/period_difficulty_retarget_top_defines.svh
// Assertion macros shared by the retarget checker.
// Needs clock and reset signals in the scope where they are used.
`ifndef PERIOD_DIFFICULTY_RETARGET_TOP_DEFINES_SVH
`define PERIOD_DIFFICULTY_RETARGET_TOP_DEFINES_SVH

// Check a condition in the cycle after a trigger, outside of reset.
`define PDR_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("retarget check failed");

// Check a condition in the same cycle as a trigger, outside of reset.
`define PDR_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("retarget check failed");

// Check a condition in the cycle after reset was high.
`define PDR_ASSERT_AFTER_RESET(label, post) \
   label: assert property (@(posedge clock) reset |=> (post)) \
      else $error("retarget check failed");

`endif

// File: hdl/pdr_pkg.sv
// Types, constants and compact-target helpers for the difficulty retarget block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pdr_pkg;

   localparam int TARGET_WIDTH = 256;
   localparam int MANT_W  = 23;
   localparam int TS_W    = 33;
   localparam int SPAN_W  = TS_W + 2;
   localparam int PM_W    = MANT_W + SPAN_W;
   localparam int PROD_W  = TARGET_WIDTH + SPAN_W;
   localparam int SHIFT_W = $clog2(TARGET_WIDTH);
   localparam int NBYTE   = (TARGET_WIDTH + 7) / 8;
   localparam int PAD_W   = 8 * NBYTE;
   localparam int BIDX_W  = $clog2(NBYTE + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_SPACING    = 3'd0,
      CSR_FAST_PERIOD       = 3'd1,
      CSR_FAST_UNTIL_HEIGHT = 3'd2,
      CSR_NORMAL_INTERVAL   = 3'd3,
      CSR_POW_LIMIT_BITS    = 3'd4,
      CSR_NO_RETARGET       = 3'd5
   } csr_idx_type;

   localparam logic [16:0] RST_TARGET_SPACING  = 17'd600;
   localparam logic [15:0] RST_NORMAL_INTERVAL = 16'd2016;
   localparam logic [31:0] RST_POW_LIMIT_BITS  = 32'h1d00ffff;

   typedef struct packed {
      logic [16:0] target_spacing;
      logic [15:0] fast_period;
      logic [30:0] fast_until_height;
      logic [15:0] normal_interval;
      logic [31:0] pow_limit_bits;
      logic        no_retarget;
   } cfg_type;

   typedef struct packed {
      logic        no_retarget;
      logic [31:0] old_bits;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic [TS_W-1:0]   rem;
      logic [PROD_W-1:0] work;
      logic [TS_W-1:0]   divisor;
      side_type          side;
   } cell_type;

   typedef struct packed {
      logic [MANT_W-1:0]  mant;
      logic [SHIFT_W-1:0] shift;
   } dec_type;

   // Split a compact value into the mantissa bits that survive and their byte shift.
   function automatic dec_type decode_mant(input logic [31:0] bits);
      logic [7:0]        size;
      logic [MANT_W-1:0] word;
      logic [11:0]       sh;
      dec_type           d;
      size   = bits[31:24];
      word   = bits[22:0];
      sh     = {1'b0, size - 8'd3, 3'b000};
      d.mant = '0;
      d.shift = '0;
      if (size <= 8'd3) begin
         d.mant = word >> {2'(8'd3 - size), 3'b000};
      end else if (sh < 12'(TARGET_WIDTH)) begin
         for (int b = 0; b < MANT_W; b++) begin
            d.mant[b] = word[b] && ((sh + 12'(b)) < 12'(TARGET_WIDTH));
         end
         d.shift = SHIFT_W'(sh);
      end
      return d;
   endfunction

   // Expand a compact value to a full-width target.
   function automatic logic [TARGET_WIDTH-1:0] decode_full(input logic [31:0] bits);
      dec_type d;
      d = decode_mant(bits);
      return TARGET_WIDTH'(d.mant) << d.shift;
   endfunction

endpackage

// File: hdl/pdr_front.sv
// Front pipeline: interval pick, timespan, span clamp, scaled target as dividend.
// Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  pdr_pkg::cfg_type    cfg,
   input  logic                req_valid,
   input  logic [31:0]         req_old_bits,
   input  logic [31:0]         req_last_block_time,
   input  logic [31:0]         req_first_block_time,
   input  logic [30:0]         req_next_height,
   output pdr_pkg::cell_type   front_cell
);

   logic                              v1_ff, v2_ff, v3_ff;
   logic [pdr_pkg::TS_W-1:0]          ts1_ff, ts2_ff, ts3_ff;
   logic signed [32:0]                raw1_ff;
   pdr_pkg::dec_type                  dm1_ff, dm2_ff;
   pdr_pkg::side_type                 side1_ff, side2_ff, side3_ff;
   logic [pdr_pkg::SPAN_W-1:0]        span2_ff;
   logic [pdr_pkg::PM_W-1:0]          pm3_ff;
   logic [pdr_pkg::SHIFT_W-1:0]       shift3_ff;
   pdr_pkg::cell_type                 cell_ff;

   logic [15:0]                       interval;
   logic                              use_fast;
   logic [pdr_pkg::TS_W-1:0]          ts_lo;
   logic [pdr_pkg::SPAN_W-1:0]        ts_hi;
   logic [pdr_pkg::SPAN_W-1:0]        span_in;
   pdr_pkg::cell_type                 cell_in;

   // Pick the interval for this height
   always_comb begin
      use_fast = (cfg.fast_period != '0) && (cfg.fast_until_height != '0) &&
                 (req_next_height < cfg.fast_until_height);
      interval = use_fast ? cfg.fast_period : cfg.normal_interval;
   end

   // Stage 1: timespan product, raw span, compact decode
   always_ff @(posedge clock) begin
      if (advance) begin
         ts1_ff   <= pdr_pkg::TS_W'(interval) * pdr_pkg::TS_W'(cfg.target_spacing);
         raw1_ff  <= $signed({1'b0, req_last_block_time}) -
                     $signed({1'b0, req_first_block_time});
         dm1_ff   <= pdr_pkg::decode_mant(req_old_bits);
         side1_ff <= '{no_retarget: cfg.no_retarget, old_bits: req_old_bits};
      end
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   // Clamp the span to a quarter and four times the timespan
   always_comb begin
      ts_lo = ts1_ff >> 2;
      ts_hi = {ts1_ff, 2'b00};
      if (raw1_ff[32] || (pdr_pkg::SPAN_W'(raw1_ff[31:0]) < pdr_pkg::SPAN_W'(ts_lo))) begin
         span_in = pdr_pkg::SPAN_W'(ts_lo);
      end else if (pdr_pkg::SPAN_W'(raw1_ff[31:0]) > ts_hi) begin
         span_in = ts_hi;
      end else begin
         span_in = pdr_pkg::SPAN_W'(raw1_ff[31:0]);
      end
   end

   // Stage 2: hold clamped span
   always_ff @(posedge clock) begin
      if (advance) begin
         ts2_ff   <= ts1_ff;
         span2_ff <= span_in;
         dm2_ff   <= dm1_ff;
         side2_ff <= side1_ff;
      end
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   // Stage 3: mantissa times span
   always_ff @(posedge clock) begin
      if (advance) begin
         ts3_ff    <= ts2_ff;
         pm3_ff    <= pdr_pkg::PM_W'(dm2_ff.mant) * pdr_pkg::PM_W'(span2_ff);
         shift3_ff <= dm2_ff.shift;
         side3_ff  <= side2_ff;
      end
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   // Stage 4: place the product at its byte position
   always_comb begin
      cell_in.valid   = v3_ff;
      cell_in.rem     = '0;
      cell_in.work    = pdr_pkg::PROD_W'(pm3_ff) << shift3_ff;
      cell_in.divisor = ts3_ff;
      cell_in.side    = side3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign front_cell = cell_ff;

endmodule

// File: hdl/pdr_div_cell.sv
// One cell of the divider chain: resolves one quotient bit and passes the word on.
// Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  pdr_pkg::cell_type up_cell,
   output pdr_pkg::cell_type dn_cell
);

   logic [pdr_pkg::TS_W:0] trial;
   logic                   take;
   pdr_pkg::cell_type      cell_in;
   pdr_pkg::cell_type      cell_ff;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial   = {up_cell.rem, up_cell.work[pdr_pkg::PROD_W-1]};
      take    = trial >= {1'b0, up_cell.divisor};
      cell_in = up_cell;
      cell_in.rem  = take ? pdr_pkg::TS_W'(trial - {1'b0, up_cell.divisor})
                          : pdr_pkg::TS_W'(trial);
      cell_in.work = {up_cell.work[pdr_pkg::PROD_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign dn_cell = cell_ff;

endmodule

// File: hdl/pdr_back.sv
// Back pipeline: cap at the pow limit, find the top byte, re-encode as compact.
// Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [31:0]       pow_limit_bits,
   input  pdr_pkg::cell_type up_cell,
   output logic              rsp_valid,
   output logic [31:0]       rsp_new_bits
);

   logic [pdr_pkg::TARGET_WIDTH-1:0] limit;
   logic [pdr_pkg::TARGET_WIDTH-1:0] capped;
   logic                             va_ff, vb_ff, out_valid_ff;
   logic [pdr_pkg::TARGET_WIDTH-1:0] val_a_ff;
   logic [pdr_pkg::PAD_W-1:0]        val_b_ff;
   pdr_pkg::side_type                side_a_ff, side_b_ff;
   logic [pdr_pkg::BIDX_W-1:0]       size_in, size_b_ff;
   logic [pdr_pkg::PAD_W-1:0]        val_pad;
   logic [pdr_pkg::PAD_W+23:0]       window;
   logic [23:0]                      mant;
   logic [pdr_pkg::BIDX_W:0]         size_adj;
   logic [31:0]                      bits_in, out_bits_ff;

   // Cap the quotient at the decoded limit
   always_comb begin
      limit  = pdr_pkg::decode_full(pow_limit_bits);
      capped = (up_cell.work > pdr_pkg::PROD_W'(limit)) ? limit
             : up_cell.work[pdr_pkg::TARGET_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         val_a_ff  <= capped;
         side_a_ff <= up_cell.side;
      end
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= up_cell.valid;
      end
   end

   // Find the highest nonzero byte
   always_comb begin
      val_pad = pdr_pkg::PAD_W'(val_a_ff);
      size_in = '0;
      for (int k = 0; k < pdr_pkg::NBYTE; k++) begin
         if (val_pad[8*k +: 8] != 8'd0) size_in = pdr_pkg::BIDX_W'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         val_b_ff  <= val_pad;
         size_b_ff <= size_in;
         side_b_ff <= side_a_ff;
      end
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= va_ff;
      end
   end

   // Take the top three bytes, move up a byte if the sign bit would be set
   always_comb begin
      window   = {val_b_ff, 24'd0};
      mant     = window[{size_b_ff, 3'b000} +: 24];
      size_adj = {1'b0, size_b_ff};
      if (mant[23]) begin
         mant     = {8'd0, mant[23:8]};
         size_adj = size_adj + 1'b1;
      end
      bits_in = side_b_ff.no_retarget ? side_b_ff.old_bits : {8'(size_adj), mant};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_bits_ff <= bits_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vb_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_new_bits = out_bits_ff;

endmodule

// File: hdl/period_difficulty_retarget_top.sv
// Channel  | Handshake             | Payload
// req      | req_valid/req_ready   | old_bits, last/first_block_time, next_height
// rsp      | rsp_valid/rsp_ready   | new_bits
// csr      | csr_wr_en             | csr_index, csr_wdata (no wait, no read-back)
//
// One request per cycle while no result is held; each passes through the front stages,
// then the chain of PROD_W divider cells, one quotient bit per cell, then the back stages.
// Reset clears all valid flags and loads register defaults.
// While a result waits with rsp_ready low, the whole pipe holds and req_ready drops.
// Depends on pdr_pkg, pdr_front, pdr_div_cell, pdr_back.
`timescale 1ns / 1ps

module period_difficulty_retarget_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_old_bits,
   input  logic [31:0]                     req_last_block_time,
   input  logic [31:0]                     req_first_block_time,
   input  logic [30:0]                     req_next_height,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_new_bits,
   input  logic                            csr_wr_en,
   input  logic [pdr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pdr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pdr_pkg::cfg_type  cfg_ff, cfg_in;
   logic              advance;
   pdr_pkg::cell_type chain [pdr_pkg::PROD_W+1];

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pdr_pkg::csr_idx_type'(csr_index))
            pdr_pkg::CSR_TARGET_SPACING:    cfg_in.target_spacing    = csr_wdata[16:0];
            pdr_pkg::CSR_FAST_PERIOD:       cfg_in.fast_period       = csr_wdata[15:0];
            pdr_pkg::CSR_FAST_UNTIL_HEIGHT: cfg_in.fast_until_height = csr_wdata[30:0];
            pdr_pkg::CSR_NORMAL_INTERVAL:   cfg_in.normal_interval   = csr_wdata[15:0];
            pdr_pkg::CSR_POW_LIMIT_BITS:    cfg_in.pow_limit_bits    = csr_wdata[31:0];
            pdr_pkg::CSR_NO_RETARGET:       cfg_in.no_retarget       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{target_spacing: pdr_pkg::RST_TARGET_SPACING,
                     fast_period: '0, fast_until_height: '0,
                     normal_interval: pdr_pkg::RST_NORMAL_INTERVAL,
                     pow_limit_bits: pdr_pkg::RST_POW_LIMIT_BITS,
                     no_retarget: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance the whole pipe unless a result is held
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   pdr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .advance              (advance),
      .cfg                  (cfg_ff),
      .req_valid            (req_valid),
      .req_old_bits         (req_old_bits),
      .req_last_block_time  (req_last_block_time),
      .req_first_block_time (req_first_block_time),
      .req_next_height      (req_next_height),
      .front_cell           (chain[0])
   );

   for (genvar i = 0; i < pdr_pkg::PROD_W; i++) begin : g_cell
      pdr_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_cell (chain[i]),
         .dn_cell (chain[i+1])
      );
   end

   pdr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .pow_limit_bits (cfg_ff.pow_limit_bits),
      .up_cell        (chain[pdr_pkg::PROD_W]),
      .rsp_valid      (rsp_valid),
      .rsp_new_bits   (rsp_new_bits)
   );

endmodule

// File: hdl/pdr_checker.sv
// Port-level checks for the retarget block, bound to the top level.
// Depends on period_difficulty_retarget_top_defines.svh.
`timescale 1ns / 1ps
`include "period_difficulty_retarget_top_defines.svh"

module pdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_new_bits
);

   // A held result stays put
   `PDR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_new_bits))
   // Requests are taken exactly when the output can move
   `PDR_ASSERT_NOW(a_ready_rule, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   // Reset empties the pipe
   `PDR_ASSERT_AFTER_RESET(a_rst_empty, !rsp_valid && req_ready)
   // With no result held, the input never stalls on its own
   `PDR_ASSERT_NOW(a_no_self_stall, !rsp_valid, req_ready)

endmodule

bind period_difficulty_retarget_top pdr_checker u_pdr_checker (.*);

// File: tb/period_difficulty_retarget_top_test.sv
// Testbench for period_difficulty_retarget_top: directed table plus random requests
// checked against a bit-accurate retarget predictor. Depends on pdr_pkg and the RTL.
`timescale 1ns / 1ps

module period_difficulty_retarget_top_test;

   localparam int DRAIN_CYCLES = 320;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 700;
   localparam int PHASE_ITEMS  = 90;

   typedef struct {
      int          preset;
      logic [31:0] old_bits;
      logic [31:0] last_t;
      logic [31:0] first_t;
      logic [30:0] height;
      bit          typed;
      logic [31:0] bits_exp;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_old_bits = '0;
   logic [31:0] req_last_block_time = '0;
   logic [31:0] req_first_block_time = '0;
   logic [30:0] req_next_height = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_new_bits;
   logic        csr_wr_en = 1'b0;
   logic [pdr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pdr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pdr_pkg::cfg_type cfg_now;
   logic [31:0] bits_due[$];
   bit          typed_now;
   logic [31:0] typed_bits;
   bit          calm;
   int          hold_request;
   int          mismatches;
   int          cycles;

   period_difficulty_retarget_top dut (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cycle guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("period_difficulty_retarget_top: mismatch");
         $finish;
      end
   end

   // Expand a compact value to the wide working target; bits at 256 and up drop.
   function automatic logic [319:0] target_of(input logic [31:0] bits);
      logic [7:0]   e;
      logic [22:0]  w;
      logic [319:0] v;
      e = bits[31:24];
      w = bits[22:0];
      if (e <= 8'd3)
         v = 320'(w >> (8 * (3 - int'(e))));
      else
         v = 320'(w) << (8 * (int'(e) - 3));
      v[319:256] = '0;
      return v;
   endfunction

   // Pack a wide target back into compact form, with the mantissa carry.
   function automatic logic [31:0] compact_of(input logic [319:0] v);
      int          top;
      int          size;
      logic [31:0] mant;
      top = 0;
      for (int i = 319; i >= 0; i--) begin
         if (v[i] && top == 0) top = i + 1;
      end
      size = (top + 7) / 8;
      if (size <= 3)
         mant = 32'(v[23:0]) << (8 * (3 - size));
      else
         mant = 32'(24'(v >> (8 * (size - 3))));
      if (mant[23]) begin
         mant = mant >> 8;
         size++;
      end
      return {8'(size), mant[23:0]};
   endfunction

   // Work out the new compact target for one request under the given settings.
   function automatic logic [31:0] retarget_bits(input pdr_pkg::cfg_type c,
         input logic [31:0] old_bits, input logic [31:0] last_t, input logic [31:0] first_t,
         input logic [30:0] height);
      longint       interval;
      longint       ts;
      longint       span;
      logic [319:0] quot;
      logic [319:0] lim;
      if (c.no_retarget) return old_bits;
      if (c.fast_period != 0 && c.fast_until_height != 0 && height < c.fast_until_height)
         interval = longint'(c.fast_period);
      else
         interval = longint'(c.normal_interval);
      ts = interval * longint'(c.target_spacing);
      span = longint'(last_t) - longint'(first_t);
      if (span < ts / 4) span = ts / 4;
      if (span > ts * 4) span = ts * 4;
      if (ts == 0)
         quot = '1;
      else
         quot = (target_of(old_bits) * 320'(span)) / 320'(ts);
      lim = target_of(c.pow_limit_bits);
      if (quot > lim) quot = lim;
      return compact_of(quot);
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t new_bits %s: got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Record each request at acceptance; check each response against the oldest one due.
   always @(negedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (typed_now)
            bits_due.push_back(typed_bits);
         else
            bits_due.push_back(retarget_bits(cfg_now, req_old_bits, req_last_block_time,
                                             req_first_block_time, req_next_height));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (bits_due.size() == 0)
            report("unexpected", rsp_new_bits, 32'h0);
         else if (rsp_new_bits !== bits_due[0]) begin
            report("wrong", rsp_new_bits, bits_due[0]);
            void'(bits_due.pop_front());
         end else
            void'(bits_due.pop_front());
      end
   end

   // Response side: random stalls, a long hold-off on demand.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else
            stall = calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
      end
   end

   // Offer one request after a random gap (none when calm) and hold it until accepted.
   task automatic send_req(input logic [31:0] old_bits, input logic [31:0] last_t,
         input logic [31:0] first_t, input logic [30:0] height, input bit typed,
         input logic [31:0] bits_exp);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_old_bits <= old_bits;
      req_last_block_time <= last_t;
      req_first_block_time <= first_t;
      req_next_height <= height;
      typed_now = typed;
      typed_bits = bits_exp;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Stop offering, wait for every result, then let the pipe empty.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input pdr_pkg::csr_idx_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write every register; the block is idle here.
   task automatic apply_cfg(input pdr_pkg::cfg_type c);
      csr_put(pdr_pkg::CSR_TARGET_SPACING, 32'(c.target_spacing));
      csr_put(pdr_pkg::CSR_FAST_PERIOD, 32'(c.fast_period));
      csr_put(pdr_pkg::CSR_FAST_UNTIL_HEIGHT, 32'(c.fast_until_height));
      csr_put(pdr_pkg::CSR_NORMAL_INTERVAL, 32'(c.normal_interval));
      csr_put(pdr_pkg::CSR_POW_LIMIT_BITS, c.pow_limit_bits);
      csr_put(pdr_pkg::CSR_NO_RETARGET, 32'(c.no_retarget));
      csr_wr_en <= 1'b0;
      cfg_now = c;
   endtask

   function automatic pdr_pkg::cfg_type preset_cfg(input int n);
      pdr_pkg::cfg_type c;
      c = '{pdr_pkg::RST_TARGET_SPACING, 16'd0, 31'd0, pdr_pkg::RST_NORMAL_INTERVAL,
            pdr_pkg::RST_POW_LIMIT_BITS, 1'b0};
      case (n)
         1: begin
            c = '{17'd1, 16'hffff, 31'h7fffffff, 16'd1, 32'h207fffff, 1'b0};
         end
         2: begin
            c = '{17'd86400, 16'd0, 31'd0, 16'hffff, 32'h0, 1'b1};
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic pdr_pkg::cfg_type random_cfg(input int phase);
      pdr_pkg::cfg_type c;
      logic [31:0] lims[4];
      lims = '{32'h1d00ffff, 32'h207fffff, 32'hff7fffff, 32'h0};
      c.target_spacing = 17'($urandom_range(1, 86400));
      c.fast_period = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 65535));
      c.fast_until_height = 31'($urandom_range(0, 3) == 0 ? 0 : $urandom);
      c.normal_interval = 16'($urandom_range(1, 65535));
      c.pow_limit_bits = $urandom_range(0, 2) == 0 ? $urandom : lims[$urandom_range(0, 3)];
      c.no_retarget = $urandom_range(0, 7) == 0;
      if (phase == 0) begin
         c.target_spacing = 17'd1;
         c.normal_interval = 16'd1;
         c.fast_period = 16'd1;
      end else if (phase == 1) begin
         c.target_spacing = 17'd86400;
         c.normal_interval = 16'hffff;
         c.fast_period = 16'hffff;
         c.fast_until_height = 31'h7fffffff;
         c.pow_limit_bits = 32'hffffffff;
         c.no_retarget = 1'b0;
      end
      return c;
   endfunction

   // Random request: mostly plausible targets and spans near the intended timespan.
   task automatic send_random();
      logic [31:0] old_bits;
      logic [31:0] first_t;
      logic [31:0] last_t;
      logic [30:0] height;
      longint      ts;
      longint      delta;
      ts = longint'(cfg_now.normal_interval) * longint'(cfg_now.target_spacing);
      if ($urandom_range(0, 3) == 0)
         old_bits = $urandom;
      else
         old_bits = {8'($urandom_range(0, 34)), 24'($urandom)};
      first_t = $urandom;
      if ($urandom_range(0, 3) == 0)
         last_t = $urandom;
      else begin
         delta = ts * longint'($urandom_range(0, 1000)) / 200 - ts / 8;
         last_t = first_t + 32'(delta);
      end
      case ($urandom_range(0, 3))
         0: height = 31'($urandom);
         1: height = cfg_now.fast_until_height;
         2: height = cfg_now.fast_until_height - 31'd1;
         default: height = 31'($urandom_range(0, 2000));
      endcase
      send_req(old_bits, last_t, first_t, height, 1'b0, 32'h0);
   endtask

   initial begin
      row_type rows[$];
      int      preset;
      cfg_now = preset_cfg(0);
      hold_request = 0;
      calm = 1'b0;
      rows = '{
         '{0, 32'h1d00ffff, 32'd1209600, 32'd0, 31'd100, 1'b1, 32'h1d00ffff},
         '{0, 32'h1d00ffff, 32'hffffffff, 32'd0, 31'd0, 1'b1, 32'h1d00ffff},
         '{0, 32'h00000000, 32'd5, 32'd9, 31'd0, 1'b1, 32'h00000000},
         '{0, 32'h1b0404cb, 32'd0, 32'hffffffff, 31'd7, 1'b0, 32'h0},
         '{0, 32'h1b0404cb, 32'd2419200, 32'd0, 31'd7, 1'b0, 32'h0},
         '{0, 32'hff7fffff, 32'd1209600, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'h00123456, 32'd4838400, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'h01123456, 32'd4838400, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'h02123456, 32'd4838400, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'h03123456, 32'd4838400, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'h04923456, 32'd1209600, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'h037fffff, 32'd2419200, 32'd0, 31'd1, 1'b0, 32'h0},
         '{0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 1'b0, 32'h0},
         '{0, 32'h1c7fffff, 32'd302400, 32'd0, 31'd3, 1'b0, 32'h0},
         '{1, 32'h1d00ffff, 32'd65535, 32'd0, 31'd0, 1'b0, 32'h0},
         '{1, 32'h1d00ffff, 32'd100, 32'd0, 31'h7ffffffe, 1'b0, 32'h0},
         '{1, 32'h1d00ffff, 32'd100, 32'd0, 31'h7fffffff, 1'b0, 32'h0},
         '{1, 32'h207fffff, 32'hffffffff, 32'd0, 31'h7fffffff, 1'b0, 32'h0},
         '{2, 32'hffffffff, 32'd0, 32'hffffffff, 31'd0, 1'b1, 32'hffffffff},
         '{2, 32'h12345678, 32'd1, 32'd2, 31'd5, 1'b1, 32'h12345678},
         '{2, 32'h00000000, 32'hffffffff, 32'd0, 31'h7fffffff, 1'b1, 32'h00000000}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; switch settings when a row asks for a different preset
      preset = 0;
      foreach (rows[i]) begin
         if (rows[i].preset != preset) begin
            drain();
            preset = rows[i].preset;
            apply_cfg(preset_cfg(preset));
         end
         send_req(rows[i].old_bits, rows[i].last_t, rows[i].first_t, rows[i].height,
                  rows[i].typed, rows[i].bits_exp);
      end

      // random phases: extremes first, then a long response hold-off, then no idling, then plain random
      for (int p = 0; p < 6; p++) begin
         drain();
         apply_cfg(random_cfg(p));
         calm = (p == 3);
         if (p == 2) hold_request = HOLD_CYCLES;
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end
      calm = 1'b0;

      drain();
      if (mismatches == 0)
         $display("period_difficulty_retarget_top: match");
      else
         $display("period_difficulty_retarget_top: mismatch");
      $finish;
   end

endmodule
